// File: design/mctt_pkg.sv
`timescale 1ns / 1ps

package mctt_pkg;

	// Field widths
	localparam int TICK_W     = 5;
	localparam int BEAT_W     = 4;
	localparam int BAR_W      = 16;
	localparam int TIME_W     = 48;
	localparam int TEMPO_W    = 16;
	localparam int SUM_W      = 20;
	localparam int RAMP_W     = 9;
	localparam int SAMPLE_W   = 10;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;

	// Shared divider geometry: 25-bit dividend and divisor, 16-bit quotient
	localparam int DIVIDEND_W = 25;
	localparam int DIVISOR_W  = 25;
	localparam int QUO_W      = 16;
	localparam int DIV_STEPS  = QUO_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// Tempo constants
	localparam logic [DIVIDEND_W-1:0] TEMPO_NUM = 25'd25000000;
	localparam logic [TIME_W-1:0]     SAT_DELTA = 48'd382;
	localparam logic [TEMPO_W-1:0]    TEMPO_MAX = 16'hFFFF;

	// Position constants
	localparam logic [TICK_W-1:0] BEAT_TICKS = 5'd24;
	localparam logic [CFG_W-1:0]  BPB_MAX    = 5'd16;

	// MIDI realtime status codes
	localparam logic [7:0] MIDI_CLOCK = 8'd248;
	localparam logic [7:0] MIDI_START = 8'd250;

	// Operation codes
	localparam logic OP_MIDI   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_BAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TICK_A  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TICK_B  = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEMPO,
		ST_TDIV,
		ST_PUSH,
		ST_AVG,
		ST_ADIV
	} seq_state_t;

	// Request to the shared divider
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	// Push command to the tempo ring
	typedef struct packed {
		logic               push;
		logic [TEMPO_W-1:0] value;
	} ring_cmd_t;

endpackage

// File: design/midi_clock_tempo_tracker_core.sv
`timescale 1ns / 1ps

// MIDI clock tempo tracker with metronome click. Each accepted transaction
// yields exactly one result transaction. A MIDI clock byte (248) advances
// tick, beat and bar at once, then turns the time since the previous clock
// into a tempo in tenths of BPM and updates the mean over the last
// AVG_DEPTH readings; both divisions run on one shared 16-step restoring
// divider, and the first division is skipped when the tempo saturates or
// reads as zero. Start bytes, other bytes and audio sample ticks give their
// result in the cycle after acceptance. The input is stalled while a clock
// byte is in progress or while an unread result is stalled at the output.
// The tempo ring needs no clearing after reset: a fill count keeps
// unwritten entries out of the mean. Configuration writes are expected
// only while the block is idle.
module midi_clock_tempo_tracker_core #(
	parameter int AVG_DEPTH = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [mctt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mctt_pkg::CFG_W-1:0]          cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [7:0]                          midi_byte,
	input  logic [mctt_pkg::TIME_W-1:0]         timestamp_us,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mctt_pkg::BAR_W-1:0]          bar_count,
	output logic [mctt_pkg::BEAT_W-1:0]         beat_in_bar,
	output logic [mctt_pkg::TICK_W-1:0]         tick_in_beat,
	output logic [mctt_pkg::TEMPO_W-1:0]        tempo_avg_tenths,
	output logic signed [mctt_pkg::SAMPLE_W-1:0] click_sample
);

	localparam int FILL_W = $clog2(AVG_DEPTH + 1);

	mctt_pkg::seq_state_t state_q, state_d;

	// Configuration registers
	logic [mctt_pkg::CFG_W-1:0] bpb_q;
	logic [mctt_pkg::CFG_W-1:0] click_a_q;
	logic [mctt_pkg::CFG_W-1:0] click_b_q;

	// Position and timing state
	logic [mctt_pkg::TICK_W-1:0]  tick_q;
	logic [mctt_pkg::BEAT_W-1:0]  beat_q;
	logic [mctt_pkg::BAR_W-1:0]   bar_q;
	logic [mctt_pkg::TIME_W-1:0]  last_time_q;
	logic [mctt_pkg::TIME_W-1:0]  delta_q;
	logic [mctt_pkg::TEMPO_W-1:0] tempo_q;
	logic [mctt_pkg::TEMPO_W-1:0] avg_q;
	logic [mctt_pkg::RAMP_W-1:0]  ramp_q;

	// Output register
	logic                           out_valid_q;
	logic [mctt_pkg::BAR_W-1:0]     out_bar_q;
	logic [mctt_pkg::BEAT_W-1:0]    out_beat_q;
	logic [mctt_pkg::TICK_W-1:0]    out_tick_q;
	logic [mctt_pkg::TEMPO_W-1:0]   out_avg_q;
	logic [mctt_pkg::SAMPLE_W-1:0]  out_sample_q;

	logic                           accept;
	logic                           is_clock;
	logic                           is_start;
	logic                           clicking;
	logic [mctt_pkg::CFG_W-1:0]     bpb_eff;
	logic [mctt_pkg::CFG_W-1:0]     beat_inc;
	logic [mctt_pkg::TICK_W-1:0]    tick_inc;
	logic                           delta_sat;
	logic                           delta_zero;

	mctt_pkg::div_req_t             div_req;
	logic                           div_done;
	logic [mctt_pkg::QUO_W-1:0]     quotient;
	mctt_pkg::ring_cmd_t            ring_cmd;
	logic [mctt_pkg::SUM_W-1:0]     ring_sum;
	logic [FILL_W-1:0]              ring_fill;
	logic                           out_load_clock;

	// Decode the incoming transaction
	always_comb begin
		accept   = in_valid && !in_stall;
		is_clock = (operation == mctt_pkg::OP_MIDI) && (midi_byte == mctt_pkg::MIDI_CLOCK);
		is_start = (operation == mctt_pkg::OP_MIDI) && (midi_byte == mctt_pkg::MIDI_START);
		clicking = (tick_q == click_a_q) || (tick_q == click_b_q);
	end

	// Stall while busy or while a result is held at the output
	assign in_stall = (state_q != mctt_pkg::ST_IDLE) || (out_valid_q && out_stall);

	// Clamp beats per bar to 1..16; classify the clock interval
	always_comb begin
		priority if (bpb_q == '0) begin
			bpb_eff = mctt_pkg::CFG_W'(1);
		end else if (bpb_q > mctt_pkg::BPB_MAX) begin
			bpb_eff = mctt_pkg::BPB_MAX;
		end else begin
			bpb_eff = bpb_q;
		end
		tick_inc   = tick_q + 1'b1;
		beat_inc   = mctt_pkg::CFG_W'(beat_q) + 1'b1;
		delta_sat  = delta_q < mctt_pkg::SAT_DELTA;
		delta_zero = delta_q > mctt_pkg::TIME_W'(mctt_pkg::TEMPO_NUM);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mctt_pkg::ST_IDLE: begin
				if (accept && is_clock) begin
					state_d = mctt_pkg::ST_TEMPO;
				end
			end
			mctt_pkg::ST_TEMPO: begin
				if (delta_sat || delta_zero) begin
					state_d = mctt_pkg::ST_PUSH;
				end else begin
					state_d = mctt_pkg::ST_TDIV;
				end
			end
			mctt_pkg::ST_TDIV: begin
				if (div_done) begin
					state_d = mctt_pkg::ST_PUSH;
				end
			end
			mctt_pkg::ST_PUSH: state_d = mctt_pkg::ST_AVG;
			mctt_pkg::ST_AVG:  state_d = mctt_pkg::ST_ADIV;
			mctt_pkg::ST_ADIV: begin
				if (div_done) begin
					state_d = mctt_pkg::ST_IDLE;
				end
			end
			default: state_d = mctt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: divider requests, ring push, result load
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = mctt_pkg::TEMPO_NUM;
		div_req.divisor  = delta_q[mctt_pkg::DIVISOR_W-1:0];
		ring_cmd.push    = 1'b0;
		ring_cmd.value   = tempo_q;
		out_load_clock   = 1'b0;
		unique case (state_q)
			mctt_pkg::ST_TEMPO: begin
				div_req.start = !(delta_sat || delta_zero);
			end
			mctt_pkg::ST_PUSH: begin
				ring_cmd.push = 1'b1;
			end
			mctt_pkg::ST_AVG: begin
				div_req.start    = 1'b1;
				div_req.dividend = mctt_pkg::DIVIDEND_W'(ring_sum);
				div_req.divisor  = mctt_pkg::DIVISOR_W'(ring_fill);
			end
			mctt_pkg::ST_ADIV: begin
				out_load_clock = div_done;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mctt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Take configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpb_q     <= mctt_pkg::CFG_W'(4);
			click_a_q <= mctt_pkg::CFG_W'(0);
			click_b_q <= mctt_pkg::CFG_W'(12);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mctt_pkg::CFG_BEATS_PER_BAR: bpb_q     <= cfg_data;
				mctt_pkg::CFG_CLICK_TICK_A:  click_a_q <= cfg_data;
				mctt_pkg::CFG_CLICK_TICK_B:  click_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the position, stamp clock arrivals, step the ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			beat_q       <= '0;
			bar_q        <= '0;
			last_time_q  <= '0;
			ramp_q       <= '0;
			avg_q        <= '0;
			delta_q      <= '0;
		end else begin
			if (accept && is_clock) begin
				delta_q      <= timestamp_us - last_time_q;
				last_time_q  <= timestamp_us;
				if (tick_inc >= mctt_pkg::BEAT_TICKS) begin
					tick_q <= '0;
					if (beat_inc >= bpb_eff) begin
						beat_q <= '0;
						bar_q  <= bar_q + 1'b1;
					end else begin
						beat_q <= beat_inc[mctt_pkg::BEAT_W-1:0];
					end
				end else begin
					tick_q <= tick_inc;
				end
			end else if (accept && is_start) begin
				tick_q <= '0;
				beat_q <= '0;
				bar_q  <= '0;
			end else if (accept && (operation == mctt_pkg::OP_SAMPLE) && clicking) begin
				ramp_q <= ramp_q + 1'b1;
			end
			if (out_load_clock) begin
				avg_q <= quotient;
			end
		end
	end

	// Pick the tempo reading: saturated, zero, or from the divider
	always_ff @(posedge clk) begin
		if (state_q == mctt_pkg::ST_TEMPO) begin
			if (delta_sat) begin
				tempo_q <= mctt_pkg::TEMPO_MAX;
			end else begin
				tempo_q <= '0;
			end
		end else if (state_q == mctt_pkg::ST_TDIV && div_done) begin
			tempo_q <= quotient;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !is_clock) || out_load_clock) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (out_load_clock) begin
			out_bar_q    <= bar_q;
			out_beat_q   <= beat_q;
			out_tick_q   <= tick_q;
			out_avg_q    <= quotient;
			out_sample_q <= '0;
		end else if (accept && !is_clock) begin
			out_bar_q  <= is_start ? '0 : bar_q;
			out_beat_q <= is_start ? '0 : beat_q;
			out_tick_q <= is_start ? '0 : tick_q;
			out_avg_q  <= avg_q;
			if ((operation == mctt_pkg::OP_SAMPLE) && clicking) begin
				out_sample_q <= {1'b1, ramp_q};
			end else begin
				out_sample_q <= '0;
			end
		end
	end

	mctt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	mctt_ring #(
		.DEPTH (AVG_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ring_cmd),
		.sum    (ring_sum),
		.fill   (ring_fill)
	);

	assign out_valid        = out_valid_q;
	assign bar_count        = out_bar_q;
	assign beat_in_bar      = out_beat_q;
	assign tick_in_beat     = out_tick_q;
	assign tempo_avg_tenths = out_avg_q;
	assign click_sample     = out_sample_q;

endmodule

// File: design/mctt_div.sv
`timescale 1ns / 1ps

module mctt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mctt_pkg::div_req_t              req,
	output logic                            done,
	output logic [mctt_pkg::QUO_W-1:0]      quotient
);

	localparam int DVR_W = mctt_pkg::DIVISOR_W;
	localparam int Q_W   = mctt_pkg::QUO_W;

	logic                        busy_q;
	logic                        done_q;
	logic [mctt_pkg::STEP_W-1:0] cnt_q;
	logic [DVR_W-1:0]            rem_q;
	logic [DVR_W-1:0]            dvs_q;
	logic [Q_W-1:0]              quo_q;

	logic [DVR_W:0] shifted;
	logic [DVR_W:0] diff;
	logic           fits;

	// One restoring step: shift in the next dividend bit, trial subtract
	always_comb begin
		shifted = {rem_q, quo_q[Q_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = ~diff[DVR_W];
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mctt_pkg::STEP_W'(mctt_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold remainder, divisor and the dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DVR_W'(req.dividend[mctt_pkg::DIVIDEND_W-1:Q_W]);
			quo_q <= req.dividend[Q_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVR_W-1:0] : shifted[DVR_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/mctt_ring.sv
`timescale 1ns / 1ps

module mctt_ring #(
	parameter int DEPTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mctt_pkg::ring_cmd_t               cmd,
	output logic [mctt_pkg::SUM_W-1:0]        sum,
	output logic [$clog2(DEPTH+1)-1:0]        fill
);

	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [mctt_pkg::TEMPO_W-1:0] ring_q [DEPTH];
	logic [SLOT_W-1:0]            slot_q;
	logic [FILL_W-1:0]            fill_q;
	logic [mctt_pkg::SUM_W-1:0]   sum_q;

	logic                         full;
	logic [mctt_pkg::SUM_W-1:0]   drop_val;

	// Oldest entry leaves the sum once the ring is full
	always_comb begin
		full     = (fill_q == FILL_W'(DEPTH));
		drop_val = full ? mctt_pkg::SUM_W'(ring_q[slot_q]) : '0;
	end

	// Advance slot, fill count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.push) begin
			sum_q  <= sum_q - drop_val + mctt_pkg::SUM_W'(cmd.value);
			slot_q <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Store the new reading
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_q[slot_q] <= cmd.value;
		end
	end

	assign sum  = sum_q;
	assign fill = fill_q;

	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("ring fill count beyond depth");

	a_slot_bound : assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(DEPTH - 1))
		else $error("ring write slot beyond depth");

	a_empty_sum : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> sum_q == '0)
		else $error("nonzero tempo sum with empty ring");

	a_push_grow : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && !full |=> fill_q == $past(fill_q) + 1'b1)
		else $error("fill count did not grow on push");

endmodule

// File: bench/tempo_tracker_checker.sv
`timescale 1ns / 1ps

module tempo_tracker_checker #(
	parameter int AVG_DEPTH = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic [mctt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mctt_pkg::CFG_W-1:0]           cfg_data,

	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 operation,
	input  logic [7:0]                           midi_byte,
	input  logic [mctt_pkg::TIME_W-1:0]          timestamp_us,

	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [mctt_pkg::BAR_W-1:0]           bar_count,
	input  logic [mctt_pkg::BEAT_W-1:0]          beat_in_bar,
	input  logic [mctt_pkg::TICK_W-1:0]          tick_in_beat,
	input  logic [mctt_pkg::TEMPO_W-1:0]         tempo_avg_tenths,
	input  logic signed [mctt_pkg::SAMPLE_W-1:0] click_sample,

	output int                                   fail_count,
	output int                                   results_due
);

	localparam logic [47:0] TEMPO_DIVIDEND = 48'd25000000;

	typedef struct packed {
		logic [15:0] bar;
		logic [3:0]  beat;
		logic [4:0]  tick;
		logic [15:0] tempo;
		logic [9:0]  click;
	} tracker_report_t;

	// Musical position and timing history
	int          tick_pos;
	int          beat_pos;
	logic [15:0] bar_num;
	logic [47:0] prev_clock_ts;
	logic [15:0] tempo_hist [AVG_DEPTH];
	int          hist_fill;
	int          hist_slot;
	logic [19:0] tempo_total;
	logic [8:0]  ramp;

	// Register copies
	logic [4:0]  bpb_reg;
	logic [4:0]  click_a;
	logic [4:0]  click_b;

	tracker_report_t predicted_reports [$];
	tracker_report_t want;
	tracker_report_t next_report;

	initial fail_count = 0;

	// Apply one transaction to the tracker state and form its report
	task automatic advance_tracker(input logic op, input logic [7:0] status,
			input logic [47:0] stamp, output tracker_report_t rpt);
		logic [47:0] gap_us;
		logic [47:0] ratio;
		logic [15:0] reading;
		logic [9:0]  sample;
		int          bpb;
		sample = '0;
		if (op == mctt_pkg::OP_MIDI) begin
			if (status == mctt_pkg::MIDI_CLOCK) begin
				// Measure the clock interval, saturating on short gaps
				gap_us = stamp - prev_clock_ts;
				if (gap_us == 0) begin
					reading = mctt_pkg::TEMPO_MAX;
				end else begin
					ratio = TEMPO_DIVIDEND / gap_us;
					reading = (ratio > mctt_pkg::TEMPO_MAX) ? mctt_pkg::TEMPO_MAX : ratio[15:0];
				end
				// Replace the oldest reading once the history is full
				if (hist_fill >= AVG_DEPTH)
					tempo_total = tempo_total - tempo_hist[hist_slot];
				else
					hist_fill++;
				tempo_hist[hist_slot] = reading;
				tempo_total = tempo_total + reading;
				hist_slot = (hist_slot + 1 >= AVG_DEPTH) ? 0 : hist_slot + 1;
				prev_clock_ts = stamp;
				// Advance tick, then beat, then bar
				bpb = (bpb_reg == 0) ? 1 : (bpb_reg > mctt_pkg::BPB_MAX) ?
					int'(mctt_pkg::BPB_MAX) : int'(bpb_reg);
				tick_pos++;
				if (tick_pos >= mctt_pkg::BEAT_TICKS) begin
					tick_pos = 0;
					beat_pos++;
					if (beat_pos >= bpb) begin
						beat_pos = 0;
						bar_num = bar_num + 1'b1;
					end
				end
			end else if (status == mctt_pkg::MIDI_START) begin
				bar_num = '0;
				beat_pos = 0;
				tick_pos = 0;
			end
		end else if (tick_pos == click_a || tick_pos == click_b) begin
			// Sawtooth sits at ramp - 512
			sample = {1'b1, ramp};
			ramp = ramp + 1'b1;
		end
		rpt.bar = bar_num;
		rpt.beat = beat_pos[3:0];
		rpt.tick = tick_pos[4:0];
		rpt.tempo = (hist_fill != 0) ? 16'(tempo_total / hist_fill) : 16'd0;
		rpt.click = sample;
	endtask

	function automatic void check_field(input string field, input logic [15:0] expected_val,
			input logic [15:0] actual_val);
		if (actual_val !== expected_val) begin
			$display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
				$time, field, expected_val, actual_val);
			fail_count++;
		end
	endfunction

	// Track registers, compare results, predict accepted transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_pos = 0;
			beat_pos = 0;
			bar_num = '0;
			prev_clock_ts = '0;
			hist_fill = 0;
			hist_slot = 0;
			tempo_total = '0;
			ramp = '0;
			bpb_reg = 5'd4;
			click_a = 5'd0;
			click_b = 5'd12;
			predicted_reports.delete();
			results_due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mctt_pkg::CFG_BEATS_PER_BAR: bpb_reg = cfg_data;
					mctt_pkg::CFG_CLICK_TICK_A:  click_a = cfg_data;
					mctt_pkg::CFG_CLICK_TICK_B:  click_b = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_reports.size() == 0) begin
					$display("%0t ns: unexpected result, bar %0d beat %0d tick %0d tempo %0d click %0d",
						$time, bar_count, beat_in_bar, tick_in_beat, tempo_avg_tenths,
						click_sample);
					fail_count++;
				end else begin
					want = predicted_reports.pop_front();
					check_field("bar_count", want.bar, bar_count);
					check_field("beat_in_bar", want.beat, beat_in_bar);
					check_field("tick_in_beat", want.tick, tick_in_beat);
					check_field("tempo_avg_tenths", want.tempo, tempo_avg_tenths);
					check_field("click_sample", {{6{want.click[9]}}, want.click},
						{{6{click_sample[9]}}, click_sample});
				end
			end
			if (in_valid && !in_stall) begin
				advance_tracker(operation, midi_byte, timestamp_us, next_report);
				predicted_reports.insert(predicted_reports.size(), next_report);
			end
			results_due = predicted_reports.size();
		end
	end

endmodule

// File: bench/midi_clock_tempo_tracker_core_tb.sv
`timescale 1ns / 1ps

module midi_clock_tempo_tracker_core_tb;

	localparam int          AVG_DEPTH       = 10;
	localparam logic [7:0]  MIDI_STOP       = 8'd252;
	localparam logic [1:0]  CFG_UNMAPPED    = 2'd3;
	localparam int          SETTLE_CYCLES   = 50;
	localparam int          WATCHDOG_LIMIT  = 2000;
	localparam int          ITEMS_PER_PHASE = 150;
	localparam int          PHASES          = 6;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_we;
	logic [mctt_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [mctt_pkg::CFG_W-1:0]           cfg_data;
	logic                                 in_valid;
	logic                                 in_stall;
	logic                                 operation;
	logic [7:0]                           midi_byte;
	logic [mctt_pkg::TIME_W-1:0]          timestamp_us;
	logic                                 out_valid;
	logic                                 out_stall;
	logic [mctt_pkg::BAR_W-1:0]           bar_count;
	logic [mctt_pkg::BEAT_W-1:0]          beat_in_bar;
	logic [mctt_pkg::TICK_W-1:0]          tick_in_beat;
	logic [mctt_pkg::TEMPO_W-1:0]         tempo_avg_tenths;
	logic signed [mctt_pkg::SAMPLE_W-1:0] click_sample;

	int                     fail_count;
	int                     results_due;
	int                     sent;
	int                     stuck_cycles;
	bit                     steady_flow;
	logic [47:0]            clk_ts;
	logic [4:0]             cur_a;
	logic [4:0]             cur_b;

	midi_clock_tempo_tracker_core #(.AVG_DEPTH(AVG_DEPTH)) u_top (.*);

	tempo_tracker_checker #(.AVG_DEPTH(AVG_DEPTH)) u_checker (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [47:0] rand48();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[47:0];
	endfunction

	// Mostly musical intervals, some slow enough to read as zero tempo
	function automatic logic [47:0] tempo_delta();
		if ($urandom_range(0, 9) == 0)
			return 48'($urandom_range(150001, 30000000));
		return 48'($urandom_range(382, 150000));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one transaction and hold it until accepted
	task automatic send_item(input logic op, input logic [7:0] status, input logic [47:0] stamp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		midi_byte = status;
		timestamp_us = stamp;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_clock_at(input logic [47:0] stamp);
		clk_ts = stamp;
		send_item(mctt_pkg::OP_MIDI, mctt_pkg::MIDI_CLOCK, stamp);
	endtask

	task automatic send_clock(input logic [47:0] delta);
		send_clock_at(clk_ts + delta);
	endtask

	task automatic send_sample();
		send_item(mctt_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)), rand48());
	endtask

	// Drain every outstanding result, then let the block settle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == mctt_pkg::CFG_CLICK_TICK_A)
			cur_a = value;
		else if (idx == mctt_pkg::CFG_CLICK_TICK_B)
			cur_b = value;
	endtask

	task automatic set_phase_config(input int phase);
		case (phase)
			1: begin
				write_reg(mctt_pkg::CFG_BEATS_PER_BAR, 5'd1);
				write_reg(mctt_pkg::CFG_CLICK_TICK_A, 5'd23);
				write_reg(mctt_pkg::CFG_CLICK_TICK_B, 5'd0);
			end
			2: begin
				write_reg(mctt_pkg::CFG_BEATS_PER_BAR, 5'd16);
				write_reg(mctt_pkg::CFG_CLICK_TICK_A, 5'd5);
				write_reg(mctt_pkg::CFG_CLICK_TICK_B, 5'd5);
			end
			3: begin
				// Out-of-range values: zero beats and click positions that never match
				write_reg(mctt_pkg::CFG_BEATS_PER_BAR, 5'd0);
				write_reg(mctt_pkg::CFG_CLICK_TICK_A, 5'd24);
				write_reg(mctt_pkg::CFG_CLICK_TICK_B, 5'd31);
				write_reg(CFG_UNMAPPED, 5'($urandom_range(0, 31)));
			end
			4: begin
				write_reg(mctt_pkg::CFG_BEATS_PER_BAR, 5'd31);
				write_reg(mctt_pkg::CFG_CLICK_TICK_A, 5'($urandom_range(0, 23)));
				write_reg(mctt_pkg::CFG_CLICK_TICK_B, 5'($urandom_range(0, 31)));
			end
			default: begin
				write_reg(mctt_pkg::CFG_BEATS_PER_BAR, 5'($urandom_range(1, 16)));
				write_reg(mctt_pkg::CFG_CLICK_TICK_A, 5'($urandom_range(0, 23)));
				write_reg(mctt_pkg::CFG_CLICK_TICK_B, 5'($urandom_range(0, 23)));
			end
		endcase
	endtask

	// Field extremes, saturation, time wrap, start and a full history
	task automatic run_directed();
		send_sample();
		send_sample();
		send_item(mctt_pkg::OP_MIDI, MIDI_STOP, rand48());
		send_item(mctt_pkg::OP_MIDI, 8'h00, 48'h0);
		send_item(mctt_pkg::OP_MIDI, 8'hFF, '1);
		send_clock_at(48'd0);
		send_clock(48'd1);
		send_clock(48'd381);
		send_clock(48'd382);
		send_clock_at(48'd100);
		send_clock_at('1);
		send_clock(48'd1);
		send_clock(48'd25000001);
		send_sample();
		send_item(mctt_pkg::OP_MIDI, mctt_pkg::MIDI_START, rand48());
		send_sample();
		repeat (9) send_clock(48'd20833);
		send_sample();
	endtask

	task automatic run_random(input int quota);
		int target;
		int kind;
		int pos;
		bit drained;
		target = sent + quota;
		drained = 1'b0;
		while (sent < target) begin
			// Hold off once per phase until the block has drained
			if (!drained && sent >= target - quota / 2) begin
				wait_idle();
				drained = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				repeat ($urandom_range(1, 30)) begin
					send_clock(tempo_delta());
					if ($urandom_range(0, 1))
						send_sample();
				end
			end else if (kind < 65) begin
				// Restart, walk to a click position, then play samples there
				pos = $urandom_range(0, 1) ? cur_b : cur_a;
				if (pos > 23)
					pos = $urandom_range(0, 23);
				send_item(mctt_pkg::OP_MIDI, mctt_pkg::MIDI_START, rand48());
				repeat (pos) send_clock(tempo_delta());
				repeat ($urandom_range(20, 80)) send_sample();
			end else if (kind < 75) begin
				repeat ($urandom_range(5, 40)) send_sample();
			end else if (kind < 85) begin
				case ($urandom_range(0, 4))
					0: send_clock(48'd0);
					1: send_clock(48'($urandom_range(1, 381)));
					2: send_clock_at(clk_ts - 48'($urandom_range(1, 100000)));
					3: send_clock_at(rand48());
					default: send_clock(48'($urandom_range(381, 382)));
				endcase
			end else if (kind < 92) begin
				send_item(mctt_pkg::OP_MIDI,
					$urandom_range(0, 1) ? mctt_pkg::MIDI_START : MIDI_STOP, rand48());
			end else begin
				send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), rand48());
			end
		end
	endtask

	// Receiver backpressure: mostly short, a few long stalls
	initial begin
		int r;
		int len;
		out_stall = 1'b0;
		forever begin
			if (steady_flow) begin
				out_stall = 1'b0;
				@(negedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_stall = 1'b0;
					len = $urandom_range(1, 10);
				end else if (r < 90) begin
					out_stall = 1'b1;
					len = $urandom_range(1, 3);
				end else if (r < 97) begin
					out_stall = 1'b1;
					len = $urandom_range(4, 12);
				end else begin
					out_stall = 1'b1;
					len = $urandom_range(30, 60);
				end
				repeat (len) @(negedge clk);
			end
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL midi_clock_tempo_tracker_core");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = mctt_pkg::CFG_BEATS_PER_BAR;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = mctt_pkg::OP_MIDI;
		midi_byte = '0;
		timestamp_us = '0;
		steady_flow = 1'b0;
		sent = 0;
		stuck_cycles = 0;
		clk_ts = '0;
		cur_a = 5'd0;
		cur_b = 5'd12;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				set_phase_config(phase);
			end
			steady_flow = (phase == PHASES - 1);
			run_random(ITEMS_PER_PHASE);
		end
		steady_flow = 1'b0;
		wait_idle();

		if (fail_count == 0 && results_due == 0)
			$display("PASS midi_clock_tempo_tracker_core");
		else
			$display("FAIL midi_clock_tempo_tracker_core");
		$finish;
	end

endmodule
